/* sv/low_light_pixel_tone_map_defines.svh */
// Assertion macros used by the tone-map RTL.
// Depends on nothing; clock and reset are the module's own ports.
`ifndef LOW_LIGHT_PIXEL_TONE_MAP_DEFINES_SVH
`define LOW_LIGHT_PIXEL_TONE_MAP_DEFINES_SVH

// same-cycle implication
`define LLPTM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LLPTM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/llptm_pkg.sv */
// Shared constants, types and helpers of the low-light tone map.
// Used by llptm_noise_ram and low_light_pixel_tone_map.
package llptm_pkg;

   // field widths
   localparam int CH_W     = 16;
   localparam int SCL_W    = 24;
   localparam int SUM_W    = 26;
   localparam int GAIN_W   = 32;
   localparam int RECIP_W  = 32;
   localparam int NOISE_W  = 18;
   localparam int POS_W    = 7;
   localparam int ALPHA_W  = 17;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   localparam int NOISE_DIM_DEF = 128;

   // Q1.16 one
   localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'h10000;

   // divide by three: floor(x * DIV3_MUL / 2^DIV3_SHIFT) == floor(x / 3) for x < 2^26
   localparam logic [SUM_W-1:0] DIV3_MUL   = 26'd44739243;
   localparam int               DIV3_SHIFT = 27;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_GRAY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_GRAY  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAY_RECIP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_EN   = 3'd4;

   // register reset values
   localparam logic [GAIN_W-1:0]  GAIN_RST       = 32'h0001_0000;
   localparam logic [SUM_W-1:0]   START_GRAY_RST = '0;
   localparam logic [SUM_W-1:0]   FULL_GRAY_RST  = '0;
   localparam logic [RECIP_W-1:0] GRAY_RECIP_RST = 32'hFFFF_FFFF;

   // request command codes
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_LOAD  = 1'b1;

   // noise table access, one per pipeline advance
   typedef struct packed {
      logic                       adv;
      logic                       wr;
      logic [POS_W-1:0]           row;
      logic [POS_W-1:0]           col;
      logic signed [NOISE_W-1:0]  wdata;
   } noise_cmd_type;

   // position modulo table size by repeated subtraction (dim >= 16, at most 8 steps)
   function automatic logic [POS_W-1:0] wrap_index(input logic [POS_W-1:0] v,
                                                   input int unsigned dim);
      logic [POS_W-1:0] r;
      r = v;
      for (int i = 0; i < 8; i++) begin
         if (int'(r) >= int'(dim)) begin
            r = r - POS_W'(dim);
         end
      end
      return r;
   endfunction

endpackage

/* sv/llptm_noise_ram.sv */
// Noise table: wraps the request position, then writes or reads one entry.
// Depends on llptm_pkg (noise_cmd_type, wrap_index).
module llptm_noise_ram #(
   parameter int NOISE_DIM = llptm_pkg::NOISE_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  llptm_pkg::noise_cmd_type            cmd,
   output logic signed [llptm_pkg::NOISE_W-1:0] rdata
);

   localparam int IDX_W  = $clog2(NOISE_DIM);
   localparam int DEPTH  = NOISE_DIM * NOISE_DIM;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [IDX_W-1:0]                    row_ff, row_in;
   logic [IDX_W-1:0]                    col_ff, col_in;
   logic                                wr_ff, wr_in;
   logic signed [llptm_pkg::NOISE_W-1:0] wdata_ff;
   logic [ADDR_W-1:0]                   addr;
   logic signed [llptm_pkg::NOISE_W-1:0] rdata_ff;
   logic signed [llptm_pkg::NOISE_W-1:0] mem [DEPTH];

   // position wrap
   always_comb begin
      row_in = IDX_W'(llptm_pkg::wrap_index(cmd.row, NOISE_DIM));
      col_in = IDX_W'(llptm_pkg::wrap_index(cmd.col, NOISE_DIM));
      wr_in  = cmd.wr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= 1'b0;
      end else if (cmd.adv) begin
         wr_ff <= wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.adv) begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         wdata_ff <= cmd.wdata;
      end
   end

   // row-major address
   assign addr = ADDR_W'(row_ff) * ADDR_W'(NOISE_DIM) + ADDR_W'(col_ff);

   // single port: write for loads, registered read for pixels
   always_ff @(posedge clock) begin
      if (cmd.adv) begin
         if (wr_ff) begin
            mem[addr] <= wdata_ff;
         end
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* sv/low_light_pixel_tone_map.sv */
// Accepted pixel requests pass the stage registers 1 to 7 to rsp_valid; one request per cycle unless stalled.
// The whole pipeline advances when the output register is empty or being taken (req_ready).
// Noise table load requests pass through the first two stages and return no response.
// Reset (synchronous) clears stage valids and sets the control registers to their defaults;
// the noise table is not cleared and holds garbage until loaded.
module low_light_pixel_tone_map #(
   parameter int NOISE_DIM = llptm_pkg::NOISE_DIM_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // pixel / table-load requests
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_cmd,
   input  logic                                   req_has_object,
   input  logic [llptm_pkg::CH_W-1:0]             req_red_in,
   input  logic [llptm_pkg::CH_W-1:0]             req_green_in,
   input  logic [llptm_pkg::CH_W-1:0]             req_blue_in,
   input  logic [llptm_pkg::POS_W-1:0]            req_row_mod,
   input  logic [llptm_pkg::POS_W-1:0]            req_col_mod,
   input  logic signed [llptm_pkg::NOISE_W-1:0]   req_noise_value,
   // processed pixels
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [llptm_pkg::CH_W-1:0]             rsp_red_out,
   output logic [llptm_pkg::CH_W-1:0]             rsp_green_out,
   output logic [llptm_pkg::CH_W-1:0]             rsp_blue_out,
   // control registers
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [llptm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [llptm_pkg::CSR_DAT_W-1:0]        csr_wdata
);

`include "low_light_pixel_tone_map_defines.svh"

   localparam int CH_W    = llptm_pkg::CH_W;
   localparam int SCL_W   = llptm_pkg::SCL_W;
   localparam int SUM_W   = llptm_pkg::SUM_W;
   localparam int NOISE_W = llptm_pkg::NOISE_W;
   localparam int ALPHA_W = llptm_pkg::ALPHA_W;
   localparam int GAIN_W  = llptm_pkg::GAIN_W;
   localparam int RECIP_W = llptm_pkg::RECIP_W;
   localparam int MULG_W  = CH_W + GAIN_W;       // 48
   localparam int DIVP_W  = 2 * SUM_W;           // 52
   localparam int ALPP_W  = SUM_W + RECIP_W;     // 58
   localparam int BLDP_W  = ALPHA_W + SCL_W;     // 41
   localparam int BSUM_W  = BLDP_W + 1;          // 42
   localparam int OUTS_W  = SCL_W + 2;           // signed sum before clamp

   // control registers
   logic [GAIN_W-1:0]  gain_ff;
   logic [SUM_W-1:0]   start_gray_ff;
   logic [SUM_W-1:0]   full_gray_ff;
   logic [RECIP_W-1:0] gray_recip_ff;
   logic               noise_en_ff;

   logic adv;
   llptm_pkg::noise_cmd_type      noise_cmd;
   logic signed [NOISE_W-1:0]     noise_rd;

   // stage 1: captured request
   logic             s1_vld_ff, s1_vld_in;
   logic             s1_empty_ff, s1_empty_in;
   logic [CH_W-1:0]  s1_ch_ff [3];
   // stage 2: scaled channels
   logic             s2_vld_ff;
   logic             s2_empty_ff;
   logic [SCL_W-1:0] s2_ch_ff [3], s2_ch_in [3];
   logic [MULG_W-1:0] gain_prod [3];
   // stage 3: sum and compares
   logic             s3_vld_ff;
   logic             s3_empty_ff;
   logic [SCL_W-1:0] s3_ch_ff [3];
   logic [SUM_W-1:0] s3_sum_ff, s3_sum_in;
   logic [SUM_W-1:0] s3_diff_ff, s3_diff_in;
   logic             s3_lt_start_ff, s3_lt_start_in;
   logic             s3_le_full_ff, s3_le_full_in;
   logic signed [NOISE_W-1:0] s3_noise_ff, s3_noise_in;
   // stage 4: gray level and blend factor
   logic             s4_vld_ff;
   logic             s4_empty_ff;
   logic [SCL_W-1:0] s4_ch_ff [3];
   logic [SCL_W-1:0] s4_gray_ff, s4_gray_in;
   logic [ALPHA_W-1:0] s4_alpha_ff, s4_alpha_in;
   logic [ALPHA_W-1:0] s4_inv_ff, s4_inv_in;
   logic             s4_lt_start_ff, s4_le_full_ff;
   logic signed [NOISE_W-1:0] s4_noise_ff;
   logic [DIVP_W-1:0] div_prod;
   logic [ALPP_W-1:0] alpha_prod;
   logic [ALPP_W-17:0] alpha_q16;
   // stage 5: blend products
   logic             s5_vld_ff;
   logic             s5_empty_ff;
   logic [SCL_W-1:0] s5_ch_ff [3];
   logic [SCL_W-1:0] s5_gray_ff;
   logic [BLDP_W-1:0] s5_pa_ff [3], s5_pa_in [3];
   logic [BLDP_W-1:0] s5_pg_ff, s5_pg_in;
   logic             s5_lt_start_ff, s5_le_full_ff;
   logic signed [NOISE_W-1:0] s5_noise_ff;
   // stage 6: selected channel
   logic             s6_vld_ff;
   logic             s6_empty_ff;
   logic [SCL_W-1:0] s6_val_ff [3], s6_val_in [3];
   logic [BSUM_W-1:0] blend_sum [3];
   logic signed [NOISE_W-1:0] s6_noise_ff;
   // stage 7: output register
   logic             s7_vld_ff;
   logic [CH_W-1:0]  s7_ch_ff [3], s7_ch_in [3];
   logic signed [OUTS_W-1:0] noisy [3];

   // one stall for the whole pipe, released by the output register
   assign adv       = ~s7_vld_ff | rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   // control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff       <= llptm_pkg::GAIN_RST;
         start_gray_ff <= llptm_pkg::START_GRAY_RST;
         full_gray_ff  <= llptm_pkg::FULL_GRAY_RST;
         gray_recip_ff <= llptm_pkg::GRAY_RECIP_RST;
         noise_en_ff   <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            llptm_pkg::CSR_GAIN:       gain_ff       <= csr_wdata;
            llptm_pkg::CSR_START_GRAY: start_gray_ff <= csr_wdata[SUM_W-1:0];
            llptm_pkg::CSR_FULL_GRAY:  full_gray_ff  <= csr_wdata[SUM_W-1:0];
            llptm_pkg::CSR_GRAY_RECIP: gray_recip_ff <= csr_wdata;
            llptm_pkg::CSR_NOISE_EN:   noise_en_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // noise table, read in step with stages 1 and 2
   always_comb begin
      noise_cmd.adv   = adv;
      noise_cmd.wr    = req_valid & (req_cmd == llptm_pkg::CMD_LOAD);
      noise_cmd.row   = req_row_mod;
      noise_cmd.col   = req_col_mod;
      noise_cmd.wdata = req_noise_value;
   end

   llptm_noise_ram #(
      .NOISE_DIM (NOISE_DIM)
   ) u_noise_ram (
      .clock (clock),
      .reset (reset),
      .cmd   (noise_cmd),
      .rdata (noise_rd)
   );

   // stage 1 capture
   always_comb begin
      s1_vld_in   = req_valid & (req_cmd == llptm_pkg::CMD_PIXEL);
      s1_empty_in = ~req_has_object & (req_red_in == '0) & (req_green_in == '0)
                    & (req_blue_in == '0);
   end

   // stage 2: gain, floor, saturate at 24 bits
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         gain_prod[j] = MULG_W'(s1_ch_ff[j]) * MULG_W'(gain_ff);
         if (|gain_prod[j][MULG_W-1:SCL_W+16]) begin
            s2_ch_in[j] = '1;
         end else begin
            s2_ch_in[j] = gain_prod[j][SCL_W+15:16];
         end
      end
   end

   // stage 3: channel sum and gray thresholds
   always_comb begin
      s3_sum_in      = SUM_W'(s2_ch_ff[0]) + SUM_W'(s2_ch_ff[1]) + SUM_W'(s2_ch_ff[2]);
      s3_lt_start_in = s3_sum_in < start_gray_ff;
      s3_le_full_in  = s3_sum_in <= full_gray_ff;
      s3_diff_in     = s3_sum_in - full_gray_ff;
      s3_noise_in    = noise_en_ff ? noise_rd : '0;
   end

   // stage 4: sum / 3 and saturated blend factor
   always_comb begin
      div_prod    = DIVP_W'(s3_sum_ff) * DIVP_W'(llptm_pkg::DIV3_MUL);
      s4_gray_in  = div_prod[llptm_pkg::DIV3_SHIFT+SCL_W-1:llptm_pkg::DIV3_SHIFT];
      alpha_prod  = ALPP_W'(s3_diff_ff) * ALPP_W'(gray_recip_ff);
      alpha_q16   = alpha_prod[ALPP_W-1:16];
      if (alpha_q16 > (ALPP_W-16)'(llptm_pkg::ONE_Q16)) begin
         s4_alpha_in = llptm_pkg::ONE_Q16;
      end else begin
         s4_alpha_in = alpha_q16[ALPHA_W-1:0];
      end
      s4_inv_in = llptm_pkg::ONE_Q16 - s4_alpha_in;
   end

   // stage 5: alpha * channel and (1 - alpha) * gray
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         s5_pa_in[j] = BLDP_W'(s4_alpha_ff) * BLDP_W'(s4_ch_ff[j]);
      end
      s5_pg_in = BLDP_W'(s4_inv_ff) * BLDP_W'(s4_gray_ff);
   end

   // stage 6: pick original, gray or blend
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         blend_sum[j] = BSUM_W'(s5_pa_ff[j]) + BSUM_W'(s5_pg_ff);
         if (!s5_lt_start_ff) begin
            s6_val_in[j] = s5_ch_ff[j];
         end else if (s5_le_full_ff) begin
            s6_val_in[j] = s5_gray_ff;
         end else begin
            s6_val_in[j] = blend_sum[j][SCL_W+15:16];
         end
      end
   end

   // stage 7: add noise, clamp to 16 bits, empty pixels to zero
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         noisy[j] = $signed({2'b00, s6_val_ff[j]}) + OUTS_W'(s6_noise_ff);
         if (s6_empty_ff || noisy[j] < 0) begin
            s7_ch_in[j] = '0;
         end else if (noisy[j] > $signed(OUTS_W'(16'hFFFF))) begin
            s7_ch_in[j] = '1;
         end else begin
            s7_ch_in[j] = noisy[j][CH_W-1:0];
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_empty_ff <= s1_empty_in;
         s1_ch_ff[0] <= req_red_in;
         s1_ch_ff[1] <= req_green_in;
         s1_ch_ff[2] <= req_blue_in;

         s2_empty_ff <= s1_empty_ff;
         s2_ch_ff    <= s2_ch_in;

         s3_empty_ff    <= s2_empty_ff;
         s3_ch_ff       <= s2_ch_ff;
         s3_sum_ff      <= s3_sum_in;
         s3_diff_ff     <= s3_diff_in;
         s3_lt_start_ff <= s3_lt_start_in;
         s3_le_full_ff  <= s3_le_full_in;
         s3_noise_ff    <= s3_noise_in;

         s4_empty_ff    <= s3_empty_ff;
         s4_ch_ff       <= s3_ch_ff;
         s4_gray_ff     <= s4_gray_in;
         s4_alpha_ff    <= s4_alpha_in;
         s4_inv_ff      <= s4_inv_in;
         s4_lt_start_ff <= s3_lt_start_ff;
         s4_le_full_ff  <= s3_le_full_ff;
         s4_noise_ff    <= s3_noise_ff;

         s5_empty_ff    <= s4_empty_ff;
         s5_ch_ff       <= s4_ch_ff;
         s5_gray_ff     <= s4_gray_ff;
         s5_pa_ff       <= s5_pa_in;
         s5_pg_ff       <= s5_pg_in;
         s5_lt_start_ff <= s4_lt_start_ff;
         s5_le_full_ff  <= s4_le_full_ff;
         s5_noise_ff    <= s4_noise_ff;

         s6_empty_ff <= s5_empty_ff;
         s6_val_ff   <= s6_val_in;
         s6_noise_ff <= s5_noise_ff;

         s7_ch_ff <= s7_ch_in;
      end
   end

   assign rsp_valid     = s7_vld_ff;
   assign rsp_red_out   = s7_ch_ff[0];
   assign rsp_green_out = s7_ch_ff[1];
   assign rsp_blue_out  = s7_ch_ff[2];

   // checks
   `LLPTM_ASSERT_NXT(a_load_no_pixel, req_valid && req_ready && (req_cmd == llptm_pkg::CMD_LOAD), !s1_vld_ff, "table load request entered the pixel pipe")
   `LLPTM_ASSERT_NXT(a_last_stage_moves, adv && s6_vld_ff, s7_vld_ff, "pixel lost between stage 6 and output")
   `LLPTM_ASSERT_IMP(a_alpha_unit, s4_vld_ff, (s4_alpha_ff <= llptm_pkg::ONE_Q16) && ((18'(s4_alpha_ff) + 18'(s4_inv_ff)) == 18'(llptm_pkg::ONE_Q16)), "blend weights do not sum to one")
   `LLPTM_ASSERT_IMP(a_blend_range, s5_vld_ff, (blend_sum[0][BSUM_W-1:SCL_W+16] == '0) && (blend_sum[1][BSUM_W-1:SCL_W+16] == '0) && (blend_sum[2][BSUM_W-1:SCL_W+16] == '0), "blend result exceeds 24 bits")

endmodule
